@@ rtl/core/bdcp_pkg.sv @@
// Shared types and constants for the bracketed decimal command parser.
// Character codes, field and comma limits, frame kind codes and the result word layout.
// No dependencies.
package bdcp_pkg;

	localparam int FieldCount = 5;
	localparam int FieldWidth = 16;

	localparam logic [7:0] CharLBracket = 8'h5B;
	localparam logic [7:0] CharRBracket = 8'h5D;
	localparam logic [7:0] CharComma    = 8'h2C;
	localparam logic [7:0] CharZero     = 8'h30;
	localparam logic [7:0] CharNine     = 8'h39;

	localparam logic [2:0] LastField   = 3'd4;
	localparam logic [6:0] CommaMax    = 7'd127;
	localparam logic [6:0] CommasFive  = 7'd4;
	localparam logic [6:0] CommasTwo   = 7'd1;

	localparam logic [1:0] KindNone     = 2'd0;
	localparam logic [1:0] KindTwo      = 2'd1;
	localparam logic [1:0] KindFive     = 2'd2;
	localparam logic [1:0] KindOverflow = 2'd3;

	typedef logic [FieldWidth-1:0] field_t;

	typedef struct packed {
		logic [1:0] kind;
		field_t     value_four;
		field_t     value_three;
		field_t     value_two;
		field_t     value_one;
		field_t     command_code;
	} bdcp_result_t;

endpackage

@@ rtl/core/bracketed_decimal_command_parser.sv @@
// Top level of the bracketed decimal command parser: input register, parser, result slot.
// One received byte per word in, one command word per closed frame out.
// Depends on bdcp_pkg, bdcp_parse and bdcp_out_slot.
// Path: a closing bracket's command word passes the input register and then the result
// register; it waits in the input register while the result register holds an untaken word.
// Throughput: one byte per cycle; the input stalls only when a command is ready and
// the result register still holds an untaken word.
// Reset: arst_n clears all frame state and both valid flags; no frame is open after reset.
module bracketed_decimal_command_parser #(
	parameter int BUFFER_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,   // [15:0] command_code, [31:16] value_one,
	                                    // [47:32] value_two, [63:48] value_three,
	                                    // [79:64] value_four
	output logic [1:0]  m_axis_tuser    // [1:0] frame_kind
);

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   emit;
	logic                   slot_free;
	logic                   advance;
	bdcp_pkg::bdcp_result_t result;
	bdcp_pkg::bdcp_result_t out_word;

	// A byte that closes a frame waits here until the result slot can take its word.
	assign advance       = valid_s1 && (!emit || slot_free);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (s_axis_tvalid && s_axis_tready) || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	bdcp_parse #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.rx_byte (byte_s1),
		.emit    (emit),
		.result  (result)
	);

	bdcp_out_slot u_out_slot (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && emit),
		.result    (result),
		.slot_free (slot_free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_word  (out_word)
	);

	assign m_axis_tdata = {out_word.value_four, out_word.value_three, out_word.value_two,
		out_word.value_one, out_word.command_code};
	assign m_axis_tuser = out_word.kind;

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit |=> m_axis_tvalid)
		else $error("closed frame did not produce a word");

	a_held_byte_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |-> !s_axis_tready)
		else $error("input taken while the held byte is stalled");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !(advance && emit))
		else $error("untaken word overwritten");

endmodule

@@ rtl/core/bdcp_parse.sv @@
// Frame state and field accumulation for the bracketed decimal command parser.
// Takes one registered byte per advance and forms the result on a closing bracket.
// Depends on bdcp_pkg.
module bdcp_parse #(
	parameter int BUFFER_BYTES = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic [7:0]            rx_byte,
	output logic                  emit,
	output bdcp_pkg::bdcp_result_t result
);

	localparam int CountWidth = $clog2(BUFFER_BYTES + 2);
	localparam logic [CountWidth-1:0] BufferLimit = CountWidth'(BUFFER_BYTES);

	logic                        in_frame_q;
	logic [CountWidth-1:0]       byte_count_q;
	logic [6:0]                  comma_count_q;
	logic [2:0]                  field_index_q;
	logic                        parse_stopped_q;
	bdcp_pkg::field_t            acc_q [bdcp_pkg::FieldCount];

	logic                        in_frame_d;
	logic [CountWidth-1:0]       byte_count_d;
	logic [6:0]                  comma_count_d;
	logic [2:0]                  field_index_d;
	logic                        parse_stopped_d;
	bdcp_pkg::field_t            acc_d [bdcp_pkg::FieldCount];

	logic                        is_lbracket;
	logic                        is_rbracket;
	logic                        is_comma;
	logic                        is_digit;
	logic [CountWidth-1:0]       byte_count_inc;
	bdcp_pkg::field_t            acc_cur;
	bdcp_pkg::field_t            acc_next;

	assign is_lbracket = (rx_byte == bdcp_pkg::CharLBracket);
	assign is_rbracket = (rx_byte == bdcp_pkg::CharRBracket);
	assign is_comma    = (rx_byte == bdcp_pkg::CharComma);
	assign is_digit    = (rx_byte >= bdcp_pkg::CharZero) && (rx_byte <= bdcp_pkg::CharNine);

	// The count saturates one past the buffer size, which marks overflow.
	assign byte_count_inc = (byte_count_q <= BufferLimit) ? byte_count_q + 1'b1 : byte_count_q;

	// Times ten as two shifts and an add; the digit value is the low nibble.
	assign acc_cur  = acc_q[field_index_q];
	assign acc_next = (acc_cur << 3) + (acc_cur << 1) + {12'd0, rx_byte[3:0]};

	assign emit = in_frame_q && is_rbracket && !is_lbracket;

	always_comb begin
		result = '0;
		if (byte_count_inc > BufferLimit) begin
			result.kind = bdcp_pkg::KindOverflow;
		end else if (comma_count_q == bdcp_pkg::CommasFive) begin
			result.kind         = bdcp_pkg::KindFive;
			result.command_code = acc_q[0];
			result.value_one    = acc_q[1];
			result.value_two    = acc_q[2];
			result.value_three  = acc_q[3];
			result.value_four   = acc_q[4];
		end else if (comma_count_q == bdcp_pkg::CommasTwo) begin
			result.kind         = bdcp_pkg::KindTwo;
			result.command_code = acc_q[0];
			result.value_one    = acc_q[1];
		end else begin
			result.kind = bdcp_pkg::KindNone;
		end
	end

	always_comb begin
		in_frame_d      = in_frame_q;
		byte_count_d    = byte_count_q;
		comma_count_d   = comma_count_q;
		field_index_d   = field_index_q;
		parse_stopped_d = parse_stopped_q;
		for (int i = 0; i < bdcp_pkg::FieldCount; i++) begin
			acc_d[i] = acc_q[i];
		end
		if (is_lbracket || (in_frame_q && is_rbracket)) begin
			// An opening bracket restarts; a closing one ends the frame.
			in_frame_d      = is_lbracket;
			byte_count_d    = is_lbracket ? CountWidth'(1) : '0;
			comma_count_d   = '0;
			field_index_d   = '0;
			parse_stopped_d = 1'b0;
			for (int i = 0; i < bdcp_pkg::FieldCount; i++) begin
				acc_d[i] = '0;
			end
		end else if (in_frame_q) begin
			byte_count_d = byte_count_inc;
			if (is_comma) begin
				if (comma_count_q != bdcp_pkg::CommaMax) begin
					comma_count_d = comma_count_q + 1'b1;
				end
				if (!parse_stopped_q) begin
					if (field_index_q < bdcp_pkg::LastField) begin
						field_index_d = field_index_q + 1'b1;
					end else begin
						parse_stopped_d = 1'b1;
					end
				end
			end else if (is_digit) begin
				if (!parse_stopped_q) begin
					acc_d[field_index_q] = acc_next;
				end
			end else begin
				parse_stopped_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q      <= 1'b0;
			byte_count_q    <= '0;
			comma_count_q   <= '0;
			field_index_q   <= '0;
			parse_stopped_q <= 1'b0;
			for (int i = 0; i < bdcp_pkg::FieldCount; i++) begin
				acc_q[i] <= '0;
			end
		end else if (advance) begin
			in_frame_q      <= in_frame_d;
			byte_count_q    <= byte_count_d;
			comma_count_q   <= comma_count_d;
			field_index_q   <= field_index_d;
			parse_stopped_q <= parse_stopped_d;
			for (int i = 0; i < bdcp_pkg::FieldCount; i++) begin
				acc_q[i] <= acc_d[i];
			end
		end
	end

	a_field_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		field_index_q <= bdcp_pkg::LastField)
		else $error("field index beyond the last field");

	a_count_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= BufferLimit + 1'b1)
		else $error("byte count beyond its saturation point");

	a_idle_is_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!in_frame_q |-> (byte_count_q == '0 && comma_count_q == '0 && !parse_stopped_q))
		else $error("frame state not cleared outside a frame");

	a_emit_closes: assert property (@(posedge clk) disable iff (!arst_n)
		emit && advance |=> !in_frame_q)
		else $error("frame still open after its result");

endmodule

@@ rtl/core/bdcp_out_slot.sv @@
// Result register of the bracketed decimal command parser.
// Holds one finished command word until the downstream side takes it.
// Depends on bdcp_pkg.
module bdcp_out_slot (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  bdcp_pkg::bdcp_result_t result,
	output logic                   slot_free,
	output logic                   out_valid,
	input  logic                   out_ready,
	output bdcp_pkg::bdcp_result_t out_word
);

	logic                   valid_q;
	bdcp_pkg::bdcp_result_t word_q;

	assign slot_free = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_word  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= load || (valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= result;
		end
	end

endmodule

@@ tb/tb_bracketed_decimal_command_parser.sv @@
// Self-checking testbench for bracketed_decimal_command_parser: a directed table of frames,
// then random frames, noise and broken frames, with random idling on both stream sides.
// Depends on bdcp_pkg and the parser RTL only.
`timescale 1ns / 1ps

module tb_bracketed_decimal_command_parser;

	localparam int BufferBytes = 64;
	localparam int RandomBytes = 1150;

	typedef struct {
		int                 pad;    // '0' bytes inserted straight after the first character
		string              text;
		bit                 typed;
		logic [1:0]         kind;
		bdcp_pkg::field_t   code;
		bdcp_pkg::field_t   v1;
		bdcp_pkg::field_t   v2;
		bdcp_pkg::field_t   v3;
		bdcp_pkg::field_t   v4;
	} frame_row_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;   // [15:0] command_code, [31:16] value_one,
	                             // [47:32] value_two, [63:48] value_three,
	                             // [79:64] value_four
	logic [1:0]  m_axis_tuser;   // [1:0] frame_kind

	// Parser state as the testbench sees it.
	bit               frame_open;
	int               frame_len;
	int               commas_seen;
	int               field_pos;
	bit               parse_halted;
	bdcp_pkg::field_t field_acc [bdcp_pkg::FieldCount];

	bdcp_pkg::bdcp_result_t expected_cmds[$];
	logic [7:0]             burst[$];
	int                     mismatches = 0;
	bit                     steady     = 1'b0;

	bracketed_decimal_command_parser #(
		.BUFFER_BYTES(BufferBytes)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic void clear_frame();
		frame_len    = 0;
		commas_seen  = 0;
		field_pos    = 0;
		parse_halted = 1'b0;
		foreach (field_acc[i])
			field_acc[i] = '0;
	endfunction

	// Advances the parser state by one byte; returns 1 when the byte closes a frame.
	function automatic bit parse_byte(input logic [7:0] b, output bdcp_pkg::bdcp_result_t cmd);
		cmd = '0;
		if (b == bdcp_pkg::CharLBracket) begin
			clear_frame();
			frame_open = 1'b1;
			frame_len  = 1;
			return 1'b0;
		end
		if (!frame_open)
			return 1'b0;
		if (frame_len <= BufferBytes)
			frame_len++;
		if (b == bdcp_pkg::CharRBracket) begin
			if (frame_len > BufferBytes) begin
				cmd.kind = bdcp_pkg::KindOverflow;
			end else if (commas_seen == bdcp_pkg::CommasFive) begin
				cmd.kind         = bdcp_pkg::KindFive;
				cmd.command_code = field_acc[0];
				cmd.value_one    = field_acc[1];
				cmd.value_two    = field_acc[2];
				cmd.value_three  = field_acc[3];
				cmd.value_four   = field_acc[4];
			end else if (commas_seen == bdcp_pkg::CommasTwo) begin
				cmd.kind         = bdcp_pkg::KindTwo;
				cmd.command_code = field_acc[0];
				cmd.value_one    = field_acc[1];
			end else begin
				cmd.kind = bdcp_pkg::KindNone;
			end
			frame_open = 1'b0;
			clear_frame();
			return 1'b1;
		end
		if (b == bdcp_pkg::CharComma) begin
			if (commas_seen < bdcp_pkg::CommaMax)
				commas_seen++;
			if (!parse_halted) begin
				if (field_pos < bdcp_pkg::LastField)
					field_pos++;
				else
					parse_halted = 1'b1;
			end
		end else if (b >= bdcp_pkg::CharZero && b <= bdcp_pkg::CharNine) begin
			if (!parse_halted)
				field_acc[field_pos] = bdcp_pkg::field_t'(32'(field_acc[field_pos]) * 32'd10
					+ 32'(b - bdcp_pkg::CharZero));
		end else begin
			parse_halted = 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit typed,
		input bdcp_pkg::bdcp_result_t want);
		bdcp_pkg::bdcp_result_t cmd;
		while (!steady && $urandom_range(99) < 6) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (parse_byte(b, cmd))
			expected_cmds.push_back(typed ? want : cmd);
	endtask

	function automatic logic [7:0] random_digit();
		return bdcp_pkg::CharZero + 8'($urandom_range(9));
	endfunction

	// Fills burst with one random piece of traffic; returns how many of its bytes count
	// as real input (noise outside a frame does not).
	function automatic int random_burst();
		int pick;
		int commas;
		int n;
		logic [7:0] b;
		burst.delete();
		pick = $urandom_range(99);
		if (pick < 7) begin
			n = $urandom_range(1, 4);
			repeat (n) begin
				b = 8'($urandom_range(255));
				burst.push_back(b == bdcp_pkg::CharLBracket ? bdcp_pkg::CharRBracket : b);
			end
			return 0;
		end
		burst.push_back(bdcp_pkg::CharLBracket);
		if (pick < 15) begin
			// Long frames around the buffer size, so both sides of overflow are reached.
			n = $urandom_range(BufferBytes - 10, BufferBytes + 10);
			repeat (n)
				burst.push_back($urandom_range(7) == 0 ? bdcp_pkg::CharComma
					: random_digit());
			burst.push_back(bdcp_pkg::CharRBracket);
		end else if (pick < 22) begin
			n = $urandom_range(0, 10);
			repeat (n)
				burst.push_back(8'($urandom_range(255)));
			if ($urandom_range(1))
				burst.push_back(bdcp_pkg::CharRBracket);
		end else begin
			pick   = $urandom_range(99);
			commas = pick < 50 ? 4 : pick < 85 ? 1 : $urandom_range(0, 7);
			for (int f = 0; f <= commas; f++) begin
				if (f > 0)
					burst.push_back(bdcp_pkg::CharComma);
				n = $urandom_range(9) == 0 ? $urandom_range(6, 8) : $urandom_range(0, 5);
				repeat (n)
					burst.push_back($urandom_range(99) < 3 ? 8'($urandom_range(255))
						: random_digit());
			end
			burst.push_back(bdcp_pkg::CharRBracket);
		end
		return burst.size();
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		m_axis_tready <= steady || $urandom_range(99) >= 6;
	end

	always @(posedge clk) begin
		bdcp_pkg::bdcp_result_t want;
		bdcp_pkg::bdcp_result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tuser, m_axis_tdata};
			if (expected_cmds.size() == 0) begin
				$error("command word arrived with none expected");
				mismatches++;
			end else begin
				want = expected_cmds.pop_front();
				check_field("frame_kind", want.kind, got.kind);
				check_field("command_code", want.command_code, got.command_code);
				check_field("value_one", want.value_one, got.value_one);
				check_field("value_two", want.value_two, got.value_two);
				check_field("value_three", want.value_three, got.value_three);
				check_field("value_four", want.value_four, got.value_four);
			end
		end
	end

	// In the table, '%' stands for a zero byte and '~' for 8'hFF.
	frame_row_t frame_table[] = '{
		'{0,  "x]",                              0, bdcp_pkg::KindNone, 0, 0, 0, 0, 0},
		'{0,  "[]",                              1, bdcp_pkg::KindNone, 0, 0, 0, 0, 0},
		'{0,  "[0,0]",                           1, bdcp_pkg::KindTwo, 0, 0, 0, 0, 0},
		'{0,  "[65535,65535,65535,65535,65535]", 1, bdcp_pkg::KindFive,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
		'{0,  "[1,2,3,4,5]",                     1, bdcp_pkg::KindFive, 1, 2, 3, 4, 5},
		'{0,  "[12,34]",                         1, bdcp_pkg::KindTwo, 12, 34, 0, 0, 0},
		'{0,  "[1,2,3]",                         1, bdcp_pkg::KindNone, 0, 0, 0, 0, 0},
		'{0,  "[1,2,3,4,5,6]",                   1, bdcp_pkg::KindNone, 0, 0, 0, 0, 0},
		'{0,  "[,7]",                            1, bdcp_pkg::KindTwo, 0, 7, 0, 0, 0},
		'{0,  "[,,,,]",                          1, bdcp_pkg::KindFive, 0, 0, 0, 0, 0},
		'{0,  "[65536,99999]",                   0, bdcp_pkg::KindNone, 0, 0, 0, 0, 0},
		'{0,  "[12a3,45]",                       0, bdcp_pkg::KindNone, 0, 0, 0, 0, 0},
		'{0,  "[-5,+6]",                         0, bdcp_pkg::KindNone, 0, 0, 0, 0, 0},
		'{0,  "[ 3,4 ]",                         0, bdcp_pkg::KindNone, 0, 0, 0, 0, 0},
		'{0,  "[1,%2]",                          0, bdcp_pkg::KindNone, 0, 0, 0, 0, 0},
		'{0,  "[~9,1]",                          0, bdcp_pkg::KindNone, 0, 0, 0, 0, 0},
		'{0,  "[9[8,7]",                         1, bdcp_pkg::KindTwo, 8, 7, 0, 0, 0},
		'{0,  "[3,4]]",                          0, bdcp_pkg::KindNone, 0, 0, 0, 0, 0},
		'{53, "[1,2,3,4,5]",                     1, bdcp_pkg::KindFive, 1, 2, 3, 4, 5},
		'{54, "[1,2,3,4,5]",                     1, bdcp_pkg::KindOverflow, 0, 0, 0, 0, 0},
		'{0,  "[7,8,9,1,2[",                     0, bdcp_pkg::KindNone, 0, 0, 0, 0, 0}
	};

	initial begin
		bdcp_pkg::bdcp_result_t want;
		logic [7:0]             b;
		int                     counted;
		frame_open = 1'b0;
		clear_frame();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (frame_table[r]) begin
			want = '{kind: frame_table[r].kind, value_four: frame_table[r].v4,
				value_three: frame_table[r].v3, value_two: frame_table[r].v2,
				value_one: frame_table[r].v1, command_code: frame_table[r].code};
			for (int i = 0; i < frame_table[r].text.len(); i++) begin
				b = frame_table[r].text[i];
				if (b == "%")
					b = 8'h00;
				else if (b == "~")
					b = 8'hFF;
				send_byte(b, frame_table[r].typed, want);
				if (i == 0)
					repeat (frame_table[r].pad)
						send_byte(bdcp_pkg::CharZero, frame_table[r].typed, want);
			end
		end

		counted = 0;
		while (counted < RandomBytes) begin
			// A stretch in the middle runs with both sides always ready.
			steady = counted >= RandomBytes / 3 && counted < RandomBytes / 2;
			counted += random_burst();
			foreach (burst[i])
				send_byte(burst[i], 1'b0, '0);
		end
		steady = 1'b0;
		s_axis_tvalid <= 1'b0;

		while (expected_cmds.size() != 0)
			@(posedge clk);
		// A command passes through the input register and then the result register after its
		// closing bracket is taken; keep clocking so that any stray word is still caught.
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
